>>> rtl/deq_pkg.sv
// Shared types for the double-ended queue: operation kinds and the control/status bundles.
package deq_pkg;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_PUSH,
        KIND_POP,
        KIND_SEARCH
    } op_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted input item
        logic exec;      // carry out the first step of the request
        logic pop_done;  // deliver the word read for a pop
        logic scan;      // compare one entry of a search
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_kind_t kind;     // kind of the held request
        logic     empty;    // queue holds no word
        logic     scan_end; // search found a match or ran out of entries
        logic     out_free; // output register can take a result
    } deq_sts_t;

endpackage

>>> rtl/deq_ctrl.sv
// Controller state machine of the double-ended queue.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  deq_sts_t sts,
    output deq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    if (sts.kind == KIND_POP && !sts.empty)
                    begin
                        state_next = ST_POP;
                    end
                    else if (sts.kind == KIND_SEARCH && !sts.empty)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.load     = ready_reg && s_tvalid;
    assign cmd.exec     = (state_reg == ST_EXEC) && sts.out_free;
    assign cmd.pop_done = (state_reg == ST_POP);
    assign cmd.scan     = (state_reg == ST_SCAN);

endmodule

>>> rtl/deq_dpath.sv
// Datapath of the double-ended queue: ring store, pointers, search counter and output register.
module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  in_opcode,
    input  logic [31:0] in_value,
    input  deq_cmd_t    cmd,
    output deq_sts_t    sts,
    input  logic        m_tready,
    output logic        out_valid,
    output logic [1:0]  out_status,
    output logic [31:0] out_popped,
    output logic [4:0]  out_pos,
    output logic [4:0]  out_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_REAR  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_REAR   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;

    logic [2:0]    op_reg;
    logic [31:0]   val_reg;
    logic [IW-1:0] front_reg;
    logic [IW-1:0] front_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] scan_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_popped_reg;
    logic [4:0]    out_pos_reg;
    logic [4:0]    out_count_reg;

    op_kind_t      kind;
    logic          is_front;
    logic          empty;
    logic          full;
    logic          match;
    logic          scan_end;
    logic          immediate;

    logic [CW-1:0] ring_off;
    logic [IW:0]   ring_sum;
    logic [IW-1:0] ring_idx;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic [CW+4:0] count_ext;
    logic [CW+4:0] occ_ext;
    logic [CW+4:0] scan_ext;

    always_comb
    begin
        case (op_reg)
            OP_PUSH_REAR, OP_PUSH_FRONT: kind = KIND_PUSH;
            OP_POP_REAR, OP_POP_FRONT:   kind = KIND_POP;
            OP_SEARCH:                   kind = KIND_SEARCH;
            default:                     kind = KIND_NOP;
        endcase
    end

    assign is_front  = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_POP_FRONT);
    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == CW'(DEPTH));
    assign match     = (rd_data_reg == val_reg);
    assign scan_end  = match || (scan_reg == occ_reg);
    assign immediate = !(((kind == KIND_POP) || (kind == KIND_SEARCH)) && !empty);

    // Offset from the front: the rear slot for a rear push, the last word for a
    // rear pop, the next entry during a search, and the front itself otherwise.
    always_comb
    begin
        ring_off = '0;
        if (cmd.scan)
        begin
            ring_off = scan_reg;
        end
        else if (kind == KIND_PUSH && !is_front)
        begin
            ring_off = occ_reg;
        end
        else if (kind == KIND_POP && !is_front)
        begin
            ring_off = occ_reg - 1'b1;
        end
    end

    assign ring_sum  = {1'b0, front_reg} + (IW+1)'(ring_off);
    assign ring_idx  = (ring_sum >= (IW+1)'(DEPTH)) ? IW'(ring_sum - (IW+1)'(DEPTH))
                                                    : ring_sum[IW-1:0];
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    assign wr_en   = cmd.exec && (kind == KIND_PUSH) && !full;
    assign wr_addr = is_front ? front_dec : ring_idx;
    assign rd_en   = (cmd.exec && !immediate) || (cmd.scan && !scan_end);
    assign rd_addr = ring_idx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            val_reg <= in_value;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        scan_next  = scan_reg;
        if (cmd.exec)
        begin
            if (kind == KIND_PUSH && !full)
            begin
                occ_next = occ_reg + 1'b1;
                if (is_front)
                begin
                    front_next = front_dec;
                end
            end
            else if (kind == KIND_POP && !empty)
            begin
                occ_next = occ_reg - 1'b1;
                if (is_front)
                begin
                    front_next = front_inc;
                end
            end
            scan_next = CW'(1);
        end
        else if (cmd.scan && !scan_end)
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    assign count_ext = {5'b0, occ_next};
    assign occ_ext   = {5'b0, occ_reg};
    assign scan_ext  = {5'b0, scan_reg};

    assign out_valid_next = (cmd.exec && immediate) || cmd.pop_done || (cmd.scan && scan_end)
                            || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            occ_reg       <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && immediate)
        begin
            out_popped_reg <= '0;
            out_pos_reg    <= '0;
            out_count_reg  <= count_ext[4:0];
            if (kind == KIND_PUSH && full)
            begin
                out_status_reg <= STAT_FULL;
            end
            else if ((kind == KIND_POP || kind == KIND_SEARCH) && empty)
            begin
                out_status_reg <= STAT_EMPTY;
            end
            else
            begin
                out_status_reg <= STAT_OK;
            end
        end
        else if (cmd.pop_done)
        begin
            out_status_reg <= STAT_OK;
            out_popped_reg <= rd_data_reg;
            out_pos_reg    <= '0;
            out_count_reg  <= occ_ext[4:0];
        end
        else if (cmd.scan && scan_end)
        begin
            out_status_reg <= match ? STAT_OK : STAT_NOT_FOUND;
            out_popped_reg <= '0;
            out_pos_reg    <= match ? scan_ext[4:0] : 5'd0;
            out_count_reg  <= occ_ext[4:0];
        end
    end

    assign sts.kind     = kind;
    assign sts.empty    = empty;
    assign sts.scan_end = scan_end;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_popped = out_popped_reg;
    assign out_pos    = out_pos_reg;
    assign out_count  = out_count_reg;

endmodule

>>> rtl/double_ended_queue_with_search.sv
// A push, a refused request or an unused opcode is carried out in the execute state, which
// registers its result; a pop reads the ring store there and delivers the word in the pop state,
// and a search walks the ring store one entry per cycle from the front in the scan state.
// The ring store has a single read port; a new item is accepted only once the last one is done.
// Reset clears the front index, the count and the output valid flag at once; the store is
// not cleared and needs no clearing pass.
module double_ended_queue_with_search
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Request items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [2:0] opcode, [34:3] value, [39:35] zero
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // [1:0] status, [33:2] popped_value,
                                  // [38:34] found_position, [43:39] entry_count, [47:44] zero
);

    deq_cmd_t    cmd;
    deq_sts_t    sts;
    logic [1:0]  out_status;
    logic [31:0] out_popped;
    logic [4:0]  out_pos;
    logic [4:0]  out_count;

    // The controller accepts an item only while idle. It starts the request only once the
    // output register is free, so a result never has to wait inside the datapath.
    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the ring store with a registered read port, the front index,
    // the count, the search position counter and the output register.
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_opcode  (s_tdata[2:0]),
        .in_value   (s_tdata[34:3]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_popped (out_popped),
        .out_pos    (out_pos),
        .out_count  (out_count)
    );

    assign m_tdata = {4'b0, out_count, out_pos, out_popped, out_status};

endmodule

>>> test/double_ended_queue_with_search_tb.sv
// Self-checking testbench for the double-ended queue with search, driven over its item streams.
`timescale 1ns / 100ps

module double_ended_queue_with_search_tb;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;
    localparam int RANDOM_ITEMS_PER_PHASE = 345;

    typedef enum logic [2:0] {
        OP_PUSH_REAR,
        OP_PUSH_FRONT,
        OP_POP_REAR,
        OP_POP_FRONT,
        OP_SEARCH,
        OP_UNUSED5,
        OP_UNUSED6,
        OP_UNUSED7
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_NOT_FOUND
    } deq_status_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } op_mix_t;

    typedef struct {
        deq_status_t        status;
        logic signed [31:0] popped_value;
        logic [4:0]         found_position;
        logic [4:0]         entry_count;
    } deq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // [2:0] opcode, [34:3] value, [39:35] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;       // [1:0] status, [33:2] popped_value,
                                // [38:34] found_position, [43:39] entry_count

    // Shadow copy of the queue contents, kept in step with accepted requests.
    logic [31:0] shadow_words [DEPTH];
    int          shadow_front = 0;
    int          shadow_count = 0;

    logic [39:0] pending_requests [$];
    deq_result_t expected_results [$];

    int   tx_idle_pct = 25;
    int   rx_idle_pct = 67;
    logic req_taken = 1'b0;
    int   fail_count = 0;
    int   stall_cycles = 0;

    // Small set of words that pushes and searches share, so that searches hit
    // and duplicates test the first-match rule.
    logic [31:0] word_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
                                   32'h0000_0064, 32'hFFFF_FF9C};

    double_ended_queue_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    // Applies one request to the shadow queue and returns the result it must produce.
    function automatic deq_result_t apply_request(deq_op_t op, logic [31:0] value);
        deq_result_t r;
        int          slot;
        logic        hit;
        r.status         = ST_OK;
        r.popped_value   = '0;
        r.found_position = '0;
        hit              = 1'b0;
        case (op)
            OP_PUSH_REAR:
                if (shadow_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    shadow_words[(shadow_front + shadow_count) % DEPTH] = value;
                    shadow_count++;
                end
            OP_PUSH_FRONT:
                if (shadow_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_words[shadow_front] = value;
                    shadow_count++;
                end
            OP_POP_REAR:
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    shadow_count--;
                    r.popped_value = shadow_words[(shadow_front + shadow_count) % DEPTH];
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.popped_value = shadow_words[shadow_front];
                    shadow_front   = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            OP_SEARCH:
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                    for (slot = 0; slot < shadow_count; slot++)
                    begin
                        if (!hit && shadow_words[(shadow_front + slot) % DEPTH] == value)
                        begin
                            hit              = 1'b1;
                            r.status         = ST_OK;
                            r.found_position = 5'(slot + 1);
                        end
                    end
                end
            default: ;  // unused opcodes leave the queue alone
        endcase
        r.entry_count = 5'(shadow_count);
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        return ($urandom_range(1) == 0) ? word_pool[$urandom_range(7)] : $urandom();
    endfunction

    // Draws one request; the mix steers the fill level toward full or empty.
    function automatic logic [39:0] random_request(op_mix_t mix);
        int      roll;
        int      push_pct;
        int      pop_pct;
        deq_op_t op;
        roll     = $urandom_range(99);
        push_pct = (mix == MIX_FILL) ? 72 : (mix == MIX_DRAIN) ? 15 : 42;
        pop_pct  = (mix == MIX_FILL) ? 12 : (mix == MIX_DRAIN) ? 68 : 40;
        if (roll < push_pct)
            op = ($urandom_range(1) == 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            op = ($urandom_range(1) == 0) ? OP_POP_REAR : OP_POP_FRONT;
        else if (roll < 97)
            op = OP_SEARCH;
        else
            op = deq_op_t'($urandom_range(7, 5));
        return {5'b0, pick_word(), op};
    endfunction

    task automatic queue_request(deq_op_t op, logic [31:0] value);
        pending_requests.push_back({5'b0, value, op});
    endtask

    task automatic add_random_phase();
        op_mix_t mix;
        mix = MIX_BALANCED;
        for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
        begin
            if (n % 24 == 0)
                mix = op_mix_t'($urandom_range(2));
            pending_requests.push_back(random_request(mix));
        end
    endtask

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: presents the next item once the current one is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || req_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_requests[0];
                    pending_requests.delete(0);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge clk)
    begin
        deq_result_t want;
        deq_result_t got;
        req_taken <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status         = deq_status_t'(m_tdata[1:0]);
            got.popped_value   = m_tdata[33:2];
            got.found_position = m_tdata[38:34];
            got.entry_count    = m_tdata[43:39];
            if (expected_results.size() == 0)
            begin
                $error("result item with none expected: tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.status != want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.popped_value != want.popped_value)
                begin
                    $error("popped_value: expected %0d, got %0d",
                           want.popped_value, got.popped_value);
                    fail_count++;
                end
                if (got.found_position != want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, got.found_position);
                    fail_count++;
                end
                if (got.entry_count != want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    fail_count++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(apply_request(deq_op_t'(s_tdata[2:0]), s_tdata[34:3]));
    end

    // Watchdog: ends the run if work is outstanding but nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        // Empty-queue cases first, then extremes of the word and each opcode.
        queue_request(OP_POP_REAR, 32'h0000_0000);
        queue_request(OP_POP_FRONT, 32'hFFFF_FFFF);
        queue_request(OP_SEARCH, 32'h0000_0000);
        queue_request(OP_PUSH_REAR, 32'h7FFF_FFFF);
        queue_request(OP_PUSH_FRONT, 32'h8000_0000);
        queue_request(OP_PUSH_REAR, 32'h8000_0000);
        queue_request(OP_SEARCH, 32'h8000_0000);
        queue_request(OP_SEARCH, 32'h7FFF_FFFF);
        queue_request(OP_SEARCH, 32'h0000_0000);
        queue_request(OP_UNUSED5, 32'hFFFF_FFFF);
        queue_request(OP_UNUSED6, 32'h5555_5555);
        queue_request(OP_UNUSED7, 32'hAAAA_AAAA);
        queue_request(OP_POP_REAR, 32'hFFFF_FFFF);
        queue_request(OP_POP_FRONT, 32'h0000_0000);
        queue_request(OP_PUSH_FRONT, 32'h0000_0000);
        queue_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_request(OP_SEARCH, 32'h7FFF_FFFF);
        queue_request(OP_POP_FRONT, 32'h0000_0000);
        queue_request(OP_POP_REAR, 32'h0000_0000);
        queue_request(OP_POP_REAR, 32'h0000_0000);
        add_random_phase();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        wait_until_drained();
        tx_idle_pct = 67;
        rx_idle_pct = 25;
        add_random_phase();

        wait_until_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_phase();

        wait_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> double_ended_queue_with_search.f
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dpath.sv
rtl/double_ended_queue_with_search.sv
test/double_ended_queue_with_search_tb.sv
